/* src/c_syntax_char_classifier_assert.svh */
// Assertion macros shared by the C syntax character classifier modules.
// No dependencies; included by each module that carries assertions.
`ifndef C_SYNTAX_CHAR_CLASSIFIER_ASSERT_SVH
`define C_SYNTAX_CHAR_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csc assertion failed");

`endif

/* src/csc_pkg.sv */
// Shared types, constants and helper functions for the C syntax character classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package csc_pkg;

    localparam int LOOKAHEAD_DEF = 9;
    localparam int PEEK_N        = 9;   // longest word plus one boundary byte
    localparam int WORD_N        = 24;

    typedef logic [7:0]              t_byte;
    typedef logic [PEEK_N-1:0][7:0]  t_peek;
    typedef logic [3:0]              t_mode;
    typedef logic [2:0]              t_class;

    localparam t_class CLS_PLAIN   = 3'd0;
    localparam t_class CLS_PREPROC = 3'd1;
    localparam t_class CLS_KEYWORD = 3'd2;
    localparam t_class CLS_TYPE    = 3'd3;
    localparam t_class CLS_COMMENT = 3'd4;
    localparam t_class CLS_LITERAL = 3'd5;
    localparam t_class CLS_NUMBER  = 3'd6;
    localparam t_class CLS_OPER    = 3'd7;

    localparam int MODE_STR = 0;
    localparam int MODE_CHR = 1;
    localparam int MODE_BLK = 2;
    localparam int MODE_LIN = 3;

    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_DQUOTE = 8'h22;
    localparam t_byte CH_SQUOTE = 8'h27;
    localparam t_byte CH_BSLASH = 8'h5C;
    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_MINUS  = 8'h2D;

    // Text of the 32-bit unsigned type name.
    localparam logic [63:0] TXT_U32_TYPE = {"uint", "32_t"};

    // Word text is right-aligned: the last character sits in bits [7:0].
    typedef struct packed {
        logic [63:0] txt;
        logic [3:0]  len;
        t_class      cls;
    } t_word;

    localparam t_word WORDS [WORD_N] = '{
        '{"#include", 4'd8, CLS_PREPROC}, '{"#define",  4'd7, CLS_PREPROC},
        '{"#ifdef",   4'd6, CLS_PREPROC}, '{"#ifndef",  4'd7, CLS_PREPROC},
        '{"#endif",   4'd6, CLS_PREPROC},
        '{"int",      4'd3, CLS_KEYWORD}, '{"char",     4'd4, CLS_KEYWORD},
        '{"void",     4'd4, CLS_KEYWORD}, '{"return",   4'd6, CLS_KEYWORD},
        '{"for",      4'd3, CLS_KEYWORD}, '{"while",    4'd5, CLS_KEYWORD},
        '{"if",       4'd2, CLS_KEYWORD}, '{"else",     4'd4, CLS_KEYWORD},
        '{"struct",   4'd6, CLS_KEYWORD}, '{"enum",     4'd4, CLS_KEYWORD},
        '{"typedef",  4'd7, CLS_KEYWORD}, '{"static",   4'd6, CLS_KEYWORD},
        '{"const",    4'd5, CLS_KEYWORD},
        '{"size_t",   4'd6, CLS_TYPE},    '{TXT_U32_TYPE, 4'd8, CLS_TYPE},
        '{"int32_t",  4'd7, CLS_TYPE},    '{"bool",     4'd4, CLS_TYPE},
        '{"float",    4'd5, CLS_TYPE},    '{"double",   4'd6, CLS_TYPE}
    };

    typedef struct packed {
        logic       hit;
        logic [3:0] len;
        t_class     cls;
        t_byte      last_ch;
    } t_match;

    // Window status toward the top level.
    typedef struct packed {
        logic req;    // head byte is ready to leave
        logic last;   // head byte is the final byte of the line
    } t_emit_ctrl;

    // Emit strobe toward the classifier.
    typedef struct packed {
        logic go;
        logic last;
    } t_emit;

    function automatic logic is_digit(input t_byte c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input t_byte c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_op(input t_byte c);
        logic r;
        case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h3D, 8'h3C,
            8'h3E, 8'h21, 8'h26, 8'h7C, 8'h5E, 8'h7E: r = 1'b1;
            default:                                  r = 1'b0;
        endcase
        return r;
    endfunction

    // Parallel compare against every word; the earliest word in the list wins.
    function automatic t_match word_match(input t_peek pk);
        t_match m;
        logic   hit;
        int     wl;
        int     idx;
        m = '0;
        for (int w = WORD_N - 1; w >= 0; w--) begin
            hit = 1'b1;
            wl  = int'(WORDS[w].len);
            for (int i = 0; i < 8; i++) begin
                idx = (i < wl) ? 8 * (wl - 1 - i) : 0;
                if ((i < wl) && (pk[i] != WORDS[w].txt[idx +: 8])) begin
                    hit = 1'b0;
                end
            end
            if (hit && !is_alnum(pk[wl])) begin
                m.hit     = 1'b1;
                m.len     = WORDS[w].len;
                m.cls     = WORDS[w].cls;
                m.last_ch = WORDS[w].txt[7:0];
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* src/csc_window.sv */
// Lookahead window for the C syntax character classifier: byte store, fill count, flush.
// Depends on csc_pkg and the assertion macro header.
`default_nettype none
`include "c_syntax_char_classifier_assert.svh"

module csc_window
    import csc_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_line_end,
    input  wire logic       i_emit_go,
    output logic            o_in_ready,
    output t_peek           o_peek,
    output t_emit_ctrl      o_ctrl
);

    localparam int FW = $clog2(LOOKAHEAD + 1);
    localparam int IW = $clog2(LOOKAHEAD);

    t_byte          r_win [LOOKAHEAD];
    t_byte          n_win [LOOKAHEAD];
    logic [FW-1:0]  r_fill, n_fill;
    logic           r_flush, n_flush;
    logic [FW-1:0]  w_pos;
    logic           w_accept;

    // Head of the window; bytes past the fill level read as zero.
    always_comb begin
        for (int i = 0; i < PEEK_N; i++) begin
            o_peek[i] = (r_fill > FW'(i)) ? r_win[i] : 8'h00;
        end
    end

    always_comb begin
        o_ctrl.req  = (r_fill == FW'(LOOKAHEAD)) || r_flush;
        o_ctrl.last = r_flush && (r_fill == FW'(1));
    end

    // Take a byte while the window has room or a byte leaves; during a flush, only as its final byte leaves.
    always_comb begin
        if (i_emit_go) begin
            o_in_ready = !r_flush || (r_fill == FW'(1));
        end else begin
            o_in_ready = !r_flush && (r_fill < FW'(LOOKAHEAD));
        end
    end

    assign w_accept = i_in_valid && o_in_ready;
    assign w_pos    = r_fill - FW'(i_emit_go);

    always_comb begin
        for (int j = 0; j < LOOKAHEAD; j++) begin
            if (i_emit_go && (j < LOOKAHEAD - 1)) begin
                n_win[j] = r_win[j + 1];
            end else begin
                n_win[j] = r_win[j];
            end
            if (w_accept && (w_pos[IW-1:0] == IW'(j))) begin
                n_win[j] = i_char_in;
            end
        end
        n_fill = w_pos + FW'(w_accept);
        if (i_emit_go && o_ctrl.last) begin
            n_flush = w_accept && i_line_end;
        end else if (w_accept && i_line_end) begin
            n_flush = 1'b1;
        end else begin
            n_flush = r_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_flush <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_flush <= n_flush;
        end
    end

    `CSC_ASSERT_IMPL(a_fill_range, i_clk, i_rst_n, 1'b1, r_fill <= FW'(LOOKAHEAD))
    `CSC_ASSERT_IMPL(a_flush_nonempty, i_clk, i_rst_n, r_flush, r_fill != '0)

endmodule

`default_nettype wire

/* src/csc_classify.sv */
// Head-byte classifier: comment and literal modes, keyword runs, per-byte class.
// Depends on csc_pkg and the assertion macro header.
`default_nettype none
`include "c_syntax_char_classifier_assert.svh"

module csc_classify
    import csc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_peek i_peek,
    input  wire t_emit i_emit,
    output t_class     o_class
);

    t_mode      r_mode, n_mode;
    t_byte      r_prev, n_prev;
    t_byte      r_before;
    logic [2:0] r_run_left, n_run_left;
    t_class     r_run_class, n_run_class;

    t_byte      c;
    t_byte      nx;
    t_mode      m;
    logic       toggled;
    logic       done;
    t_match     wm;

    assign c  = i_peek[0];
    assign nx = i_peek[1];
    assign wm = word_match(i_peek);

    always_comb begin
        n_mode      = r_mode;
        n_prev      = r_prev;
        n_run_left  = r_run_left;
        n_run_class = r_run_class;
        o_class     = CLS_PLAIN;
        m           = r_mode;
        toggled     = 1'b0;
        done        = 1'b0;

        if (r_run_left != 3'd0) begin
            // rest of a matched word or comment delimiter
            n_run_left = r_run_left - 3'd1;
            o_class    = r_run_class;
        end else begin
            if (!m[MODE_STR] && !m[MODE_CHR]) begin
                if ((c == CH_SLASH) && (nx == CH_STAR) && !m[MODE_LIN]) begin
                    n_mode           = m;
                    n_mode[MODE_BLK] = 1'b1;
                    n_run_left       = 3'd1;
                    n_run_class      = CLS_COMMENT;
                    o_class          = CLS_COMMENT;
                    done             = 1'b1;
                end else if ((c == CH_STAR) && (nx == CH_SLASH) && m[MODE_BLK]) begin
                    n_mode           = m;
                    n_mode[MODE_BLK] = 1'b0;
                    n_run_left       = 3'd1;
                    n_run_class      = CLS_COMMENT;
                    o_class          = CLS_COMMENT;
                    done             = 1'b1;
                end else if ((c == CH_SLASH) && (nx == CH_SLASH) && !m[MODE_BLK]) begin
                    m[MODE_LIN] = 1'b1;
                end
            end
            if (!done) begin
                if (!m[MODE_BLK] && !m[MODE_LIN]) begin
                    if ((c == CH_DQUOTE) && (r_prev != CH_BSLASH)) begin
                        m[MODE_STR] = !m[MODE_STR];
                        toggled     = 1'b1;
                    end
                    if ((c == CH_SQUOTE) && (r_prev != CH_BSLASH)) begin
                        m[MODE_CHR] = !m[MODE_CHR];
                        toggled     = 1'b1;
                    end
                end
                if (m[MODE_BLK] || m[MODE_LIN]) begin
                    o_class = CLS_COMMENT;
                end else if (m[MODE_STR] || m[MODE_CHR] || toggled) begin
                    o_class = CLS_LITERAL;
                end else if (!is_alnum(r_before) && wm.hit) begin
                    n_run_left  = 3'(wm.len - 4'd1);
                    n_run_class = wm.cls;
                    n_prev      = wm.last_ch;
                    o_class     = wm.cls;
                    done        = 1'b1;
                end else if (is_digit(c) || ((c == CH_MINUS) && is_digit(nx))) begin
                    o_class = CLS_NUMBER;
                end else if (is_op(c)) begin
                    o_class = CLS_OPER;
                end else begin
                    o_class = CLS_PLAIN;
                end
                if (!done) begin
                    n_prev = c;
                    if (c == CH_NL) begin
                        m[MODE_LIN] = 1'b0;
                    end
                end
                n_mode = m;
            end
        end
    end

    // Advance on every emitted byte; drop all modes after the last byte of a line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= '0;
            r_prev      <= '0;
            r_before    <= '0;
            r_run_left  <= '0;
            r_run_class <= CLS_PLAIN;
        end else if (i_emit.go) begin
            if (i_emit.last) begin
                r_mode      <= '0;
                r_prev      <= '0;
                r_before    <= '0;
                r_run_left  <= '0;
                r_run_class <= CLS_PLAIN;
            end else begin
                r_mode      <= n_mode;
                r_prev      <= n_prev;
                r_before    <= c;
                r_run_left  <= n_run_left;
                r_run_class <= n_run_class;
            end
        end
    end

    `CSC_ASSERT_NEXT(a_line_clear, i_clk, i_rst_n, i_emit.go && i_emit.last, (r_mode == '0) && (r_run_left == '0) && (r_before == '0))
    `CSC_ASSERT_IMPL(a_comment_excl, i_clk, i_rst_n, r_mode[MODE_BLK] || r_mode[MODE_LIN], !r_mode[MODE_STR] && !r_mode[MODE_CHR])
    `CSC_ASSERT_IMPL(a_blk_lin_excl, i_clk, i_rst_n, r_mode[MODE_BLK], !r_mode[MODE_LIN])

endmodule

`default_nettype wire

/* src/c_syntax_char_classifier.sv */
// Top level of the C syntax character classifier: handshakes and result register.
// Depends on csc_pkg, csc_window and csc_classify.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_char_in[7:0], i_line_end
//  out     | output    | o_out_valid / i_out_ready | o_char_out[7:0], o_char_class, o_last
//
// One byte per cycle in and out in steady state; each byte is classified by the
// head logic in the cycle it leaves the LOOKAHEAD-deep window and is held in the
// result register until its transfer. A line's first result appears once LOOKAHEAD
// bytes are held, or at line end. Line end flushes the window one byte per cycle,
// blocking new input until the final byte leaves (a new byte may enter in that
// cycle). Reset is synchronous and clears fill count, modes and the result valid.
// A stall on the output holds the window and, once full, the input.
`default_nettype none

module c_syntax_char_classifier
    import csc_pkg::*;
#(
    parameter int LOOKAHEAD = LOOKAHEAD_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    input  wire logic       i_line_end,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_char_out,
    output logic [2:0]      o_char_class,
    output logic            o_last
);

    t_peek      w_peek;
    t_emit_ctrl w_ctrl;
    t_emit      w_emit;
    t_class     w_class;
    logic       w_emit_go;

    logic       r_out_valid;
    t_byte      r_char;
    t_class     r_class;
    logic       r_last;

    // Advance the head only when the result register is free or being drained.
    assign w_emit_go = w_ctrl.req && (!r_out_valid || i_out_ready);
    assign w_emit    = '{go: w_emit_go, last: w_ctrl.last};

    csc_window #(
        .LOOKAHEAD (LOOKAHEAD)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_char_in  (i_char_in),
        .i_line_end (i_line_end),
        .i_emit_go  (w_emit_go),
        .o_in_ready (o_in_ready),
        .o_peek     (w_peek),
        .o_ctrl     (w_ctrl)
    );

    csc_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_peek  (w_peek),
        .i_emit  (w_emit),
        .o_class (w_class)
    );

    // Result register: load on emit, drop valid after a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_go) begin
            r_char  <= w_peek[0];
            r_class <= w_class;
            r_last  <= w_ctrl.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_char_out   = r_char;
    assign o_char_class = r_class;
    assign o_last       = r_last;

endmodule

`default_nettype wire

/* sim/tb_c_syntax_char_classifier.sv */
// Testbench for the C syntax character classifier: random and directed source lines,
// a cycle-free predictor of the color classes, and a scoreboard on the output channel.
// Depends on csc_pkg and c_syntax_char_classifier.
`timescale 1ns / 1ps

module tb_c_syntax_char_classifier
    import csc_pkg::*;
;

    localparam int WIN      = 9;    // lookahead depth of the block under test
    localparam int N_WORDS  = 24;
    localparam int N_EXTRA  = 36;
    localparam int HOLD_LEN = 48;   // cycles of the long receiver hold-off

    // One source byte as the sender offers it.
    typedef struct {
        t_byte ch;
        logic  eol;
    } t_src_byte;

    // One colored byte as the block should return it.
    typedef struct {
        t_byte  ch;
        t_class cls;
        logic   last;
    } t_colored_char;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] char_in   = '0;
    logic       line_end  = 1'b0;
    logic       out_ready = 1'b0;
    logic       hold_rx   = 1'b0;

    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_char_out;
    logic [2:0] o_char_class;
    logic       o_last;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    c_syntax_char_classifier #(
        .LOOKAHEAD (WIN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_in    (char_in),
        .i_line_end   (line_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_char_out   (o_char_out),
        .o_char_class (o_char_class),
        .o_last       (o_last)
    );

    // ------------------------------------------------------------------
    // Word list the classifier colors; the first hit in list order wins
    // ------------------------------------------------------------------
    string kw_text [N_WORDS] = '{
        "#include", "#define", "#ifdef", "#ifndef", "#endif",
        "int", "char", "void", "return", "for", "while", "if", "else",
        "struct", "enum", "typedef", "static", "const",
        "size_t", {"uint", "32_t"}, "int32_t", "bool", "float", "double"
    };
    t_class kw_cls [N_WORDS] = '{
        CLS_PREPROC, CLS_PREPROC, CLS_PREPROC, CLS_PREPROC, CLS_PREPROC,
        CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
        CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
        CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
        CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_TYPE, CLS_TYPE
    };

    // Other pieces of C text for the random lines: comment and quote
    // delimiters, escapes, near-miss words, numbers and every operator.
    string extra_frag [N_EXTRA] = '{
        "/*", "*/", "//", "\"", "'", "\\", "\\\"", " ", " ", "\n",
        "x", "abc", "int5", "xint", "_t", "-7", "42", "0", "(", ")",
        ";", "=", "+", "-", "*", "/", "%", "<", ">", "!",
        "&", "|", "^", "~", "#", "{"
    };

    string op_chars = "+-*/%=<>!&|^~";

    // ------------------------------------------------------------------
    // Predictor state: a copy of the window, the mode bits and the run
    // ------------------------------------------------------------------
    t_byte  win_bytes [WIN];
    int     fill      = 0;
    t_mode  modes     = '0;
    t_byte  prev_ch   = '0;
    t_byte  before_ch = '0;
    int     run_left  = 0;
    t_class run_cls   = CLS_PLAIN;

    t_src_byte     stim_q [$];
    t_src_byte     line_buf [$];
    t_colored_char pred_q [$];

    int n_items = 0;
    int n_in    = 0;
    int n_out   = 0;
    int n_err   = 0;

    function automatic bit digit_ch(input t_byte c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit word_ch(input t_byte c);
        return digit_ch(c) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic bit op_ch(input t_byte c);
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < op_chars.len(); i++)
            if (t_byte'(op_chars[i]) == c) hit = 1'b1;
        return hit;
    endfunction

    // Positions past the bytes received so far read as zero.
    function automatic t_byte win_at(input int i);
        return (i >= fill || i >= WIN) ? 8'h00 : win_bytes[i];
    endfunction

    // Color the head byte and advance the mode logic.
    function automatic t_class head_class();
        t_byte  c;
        t_byte  n;
        bit     toggled;
        bit     hit;
        int     len;
        t_class cls;
        c       = win_at(0);
        n       = win_at(1);
        toggled = 1'b0;
        // Rest of a matched word or of a comment delimiter pair.
        if (run_left > 0) begin
            run_left--;
            return run_cls;
        end
        if (!modes[MODE_STR] && !modes[MODE_CHR]) begin
            if (c == CH_SLASH && n == CH_STAR && !modes[MODE_LIN]) begin
                modes[MODE_BLK] = 1'b1;
                run_left = 1;
                run_cls  = CLS_COMMENT;
                return CLS_COMMENT;
            end
            if (c == CH_STAR && n == CH_SLASH && modes[MODE_BLK]) begin
                modes[MODE_BLK] = 1'b0;
                run_left = 1;
                run_cls  = CLS_COMMENT;
                return CLS_COMMENT;
            end
            if (c == CH_SLASH && n == CH_SLASH && !modes[MODE_BLK])
                modes[MODE_LIN] = 1'b1;
        end
        // Quotes toggle only outside comments and not after a backslash.
        if (!modes[MODE_BLK] && !modes[MODE_LIN]) begin
            if (c == CH_DQUOTE && prev_ch != CH_BSLASH) begin
                modes[MODE_STR] = ~modes[MODE_STR];
                toggled = 1'b1;
            end
            if (c == CH_SQUOTE && prev_ch != CH_BSLASH) begin
                modes[MODE_CHR] = ~modes[MODE_CHR];
                toggled = 1'b1;
            end
        end
        if (modes[MODE_BLK] || modes[MODE_LIN]) begin
            cls = CLS_COMMENT;
        end else if (modes[MODE_STR] || modes[MODE_CHR] || toggled) begin
            cls = CLS_LITERAL;
        end else begin
            if (!word_ch(before_ch)) begin
                for (int w = 0; w < N_WORDS; w++) begin
                    len = kw_text[w].len();
                    hit = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (win_at(i) != t_byte'(kw_text[w][i])) hit = 1'b0;
                    if (hit && !word_ch(win_at(len))) begin
                        run_left = len - 1;
                        run_cls  = kw_cls[w];
                        prev_ch  = t_byte'(kw_text[w][len-1]);
                        return kw_cls[w];
                    end
                end
            end
            if (digit_ch(c) || (c == CH_MINUS && digit_ch(n)))
                cls = CLS_NUMBER;
            else if (op_ch(c))
                cls = CLS_OPER;
            else
                cls = CLS_PLAIN;
        end
        prev_ch = c;
        if (c == CH_NL) modes[MODE_LIN] = 1'b0;
        return cls;
    endfunction

    // Release the head byte with its color and shift the window.
    function automatic void release_head(input logic eol);
        t_colored_char r;
        r.ch   = win_at(0);
        r.cls  = head_class();
        r.last = eol;
        pred_q.push_back(r);
        before_ch = r.ch;
        for (int i = 0; i + 1 < fill; i++) win_bytes[i] = win_bytes[i+1];
        if (fill > 0) fill--;
    endfunction

    // Expected results of one accepted source byte.
    function automatic void classify_step(input t_byte ch, input logic eol);
        int k;
        if (fill >= WIN) fill = WIN - 1;
        win_bytes[fill] = ch;
        fill++;
        if (!eol) begin
            if (fill == WIN) release_head(1'b0);
        end else begin
            k = 0;
            while (fill > 0 && k < WIN) begin
                release_head(fill == 1);
                k++;
            end
            fill      = 0;
            modes     = '0;
            prev_ch   = '0;
            before_ch = '0;
            run_left  = 0;
            run_cls   = CLS_PLAIN;
        end
    endfunction

    // ------------------------------------------------------------------
    // Line building: bytes gather in line_buf, close_line marks the end
    // ------------------------------------------------------------------
    function automatic void push_text(input string s);
        t_src_byte b;
        for (int i = 0; i < s.len(); i++) begin
            b.ch  = t_byte'(s[i]);
            b.eol = 1'b0;
            line_buf.push_back(b);
        end
    endfunction

    function automatic void close_line(input int max_len);
        t_src_byte b;
        while (line_buf.size() > max_len) void'(line_buf.pop_back());
        for (int i = 0; i < line_buf.size(); i++) begin
            b     = line_buf[i];
            b.eol = (i == line_buf.size() - 1);
            stim_q.push_back(b);
        end
        line_buf.delete();
    endfunction

    // Fill the queue of pending source bytes, then run reset and the end.
    initial begin
        t_src_byte b;
        int        tgt;
        int        pick;
        // Directed lines: lone zero byte, keyword then negative number then a
        // high byte, quote inside a string with an escaped closer, comment
        // pair then a line comment, quote inside a char literal.
        b.ch = 8'h00;
        b.eol = 1'b0;
        line_buf.push_back(b);
        close_line(WIN * 8);
        push_text("if -5");
        b.ch = 8'hFF;
        line_buf.push_back(b);
        close_line(WIN * 8);
        push_text("\"a'\\\"\"");
        close_line(WIN * 8);
        push_text("/*x*/a//b");
        close_line(WIN * 8);
        push_text("'\"'");
        close_line(WIN * 8);
        // Random lines of C fragments with some raw noise bytes; most are
        // short, a few run well past the window depth.
        while (stim_q.size() < 150) begin
            tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 18);
            while (line_buf.size() < tgt) begin
                if ($urandom_range(0, 9) == 0) begin
                    b.ch  = t_byte'($urandom_range(0, 255));
                    b.eol = 1'b0;
                    line_buf.push_back(b);
                end else begin
                    pick = $urandom_range(0, N_WORDS + N_EXTRA - 1);
                    if (pick < N_WORDS) push_text(kw_text[pick]);
                    else push_text(extra_frag[pick - N_WORDS]);
                end
            end
            close_line(tgt);
        end
        n_items = stim_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to transfer, then drain the expectations.
        while (n_in < n_items) @(posedge i_clk);
        while (pred_q.size() > 0) @(posedge i_clk);
        repeat (3 * WIN) @(posedge i_clk);
        if (n_err == 0 && pred_q.size() == 0)
            $display("tb_c_syntax_char_classifier passed");
        else
            $display("tb_c_syntax_char_classifier failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offer the next byte after a random gap; hold the payload
    // until its transfer, and predict at the transfer edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        t_src_byte nxt;
        int        in_gap;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && o_in_ready) begin
                classify_step(char_in, line_end);
                n_in++;
                // Alternate stretches of back-to-back bytes with gappy ones.
                in_gap = ((n_in % 64) < 20) ? 0 : $urandom_range(0, 3);
            end
            if (!in_valid || o_in_ready) begin
                if (in_gap > 0 || stim_q.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    in_valid <= 1'b0;
                end else begin
                    nxt = stim_q.pop_front();
                    in_valid <= 1'b1;
                    char_in  <= nxt.ch;
                    line_end <= nxt.eol;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each output transfer with the oldest expectation,
    // then drop ready for a random number of cycles
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_proc
        t_colored_char want;
        int            out_gap;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            out_gap = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pred_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result %0d: char %02h class %0d last %0b",
                                 n_out, o_char_out, o_char_class, o_last);
                end else begin
                    want = pred_q.pop_front();
                    if (o_char_out !== want.ch || o_char_class !== want.cls ||
                        o_last !== want.last) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("result %0d: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                                     n_out, want.ch, want.cls, want.last,
                                     o_char_out, o_char_class, o_last);
                    end
                end
                n_out++;
                out_gap = ((n_out % 64) < 20) ? 0 : $urandom_range(0, 3);
            end
            if (hold_rx) begin
                out_ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off mid-run: the sender keeps offering, so the
    // window fills and the block must stall its input.
    initial begin
        @(posedge i_clk);
        while (n_in < 60) @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("tb_c_syntax_char_classifier failed");
        $finish;
    end

endmodule
